@@ sv/pwsc_pkg.sv @@
// Shared constants and types for the pattern weight sum and clamp block.
`timescale 1ns / 1ps

package pwsc_pkg;

  // Parameter defaults
  localparam int NUM_TABLES_DEF  = 10;
  localparam int TABLE_DEPTH_DEF = 65536;
  localparam int WEIGHT_BITS_DEF = 16;

  // Field widths
  localparam int TABLE_W = 4;
  localparam int INDEX_W = 16;
  localparam int VALUE_W = 16;
  localparam int SCORE_W = 16;
  localparam int LIMIT_W = 15;
  localparam int SUM_W   = 24;

  // Padded stream widths
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4096);

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_WRITE  = 1'b1
  } op_t;

endpackage

@@ sv/pwsc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module pwsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/pattern_weight_sum_clamp_top.sv @@
// Top level: pattern weight table lookup, running sum and clamped score output.
//
//  channel | direction | handshake           | payload
//  s_*     | in        | s_tvalid / s_tready | tdata: table, index, weight; tuser: op; tlast
//  m_*     | out       | m_tvalid / m_tready | tdata: score
//  cfg_*   | in        | cfg_valid/cfg_ready | cfg_data: score limit
//
// One item per cycle while s_tready is high. A lookup goes through the weight RAM read
// register, then the add, saturate and clamp into the output register.
// Writes finish at the accepting edge. No clearing pass: the table is not reset.
// rst clears the running sum, the stage valid flags and the limit (4096).
// A stalled result stalls only the lookup marked last behind it; ready falls then.
`timescale 1ns / 1ps

module pattern_weight_sum_clamp_top
  import pwsc_pkg::*;
#(
  parameter int NUM_TABLES  = NUM_TABLES_DEF,
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [3:0] table_num, [19:4] entry_index, [35:20] weight_value, [39:36] zero
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [0] op
  input  logic                  s_tuser,
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [15:0] score
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [LIMIT_W-1:0]    cfg_data
);

  localparam int DEPTH  = NUM_TABLES * TABLE_DEPTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ACC_W  = ((WEIGHT_BITS > SUM_W) ? WEIGHT_BITS : SUM_W) + 1;
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'((1 << (SUM_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_W'(1 << (SUM_W - 1));

  // Input fields
  logic [TABLE_W-1:0]        table_num;
  logic [INDEX_W-1:0]        entry_index;
  logic signed [VALUE_W-1:0] weight_value;
  op_t                       op;
  logic                      accept;
  logic                      addr_ok;
  logic [ADDR_W-1:0]         mem_addr;
  logic [WEIGHT_BITS-1:0]    mem_wdata;
  logic [WEIGHT_BITS-1:0]    mem_rdata;

  // Lookup stage
  logic s1_valid;
  logic s1_ok;
  logic s1_last;
  logic s1_go;
  logic s1_emit;

  logic signed [SUM_W-1:0]   running_sum;
  logic signed [SUM_W-1:0]   running_sum_next;
  logic signed [ACC_W-1:0]   acc_wide;
  logic signed [ACC_W-1:0]   weight_ext;
  logic signed [SUM_W-1:0]   sat_sum;
  logic signed [SUM_W-1:0]   lim_pos;
  logic signed [SUM_W-1:0]   lim_neg;
  logic signed [SUM_W-1:0]   clamped;

  logic [LIMIT_W-1:0]        score_limit;
  logic                      out_valid;
  logic [SCORE_W-1:0]        score;

  assign table_num    = s_tdata[TABLE_W-1:0];
  assign entry_index  = s_tdata[TABLE_W+INDEX_W-1:TABLE_W];
  assign weight_value = s_tdata[TABLE_W+INDEX_W+VALUE_W-1:TABLE_W+INDEX_W];
  assign op           = op_t'(s_tuser);

  assign accept  = s_tvalid && s_tready;
  assign addr_ok = (32'(table_num) < NUM_TABLES) && (32'(entry_index) < TABLE_DEPTH);
  assign mem_addr = ADDR_W'(ADDR_W'(table_num) * ADDR_W'(TABLE_DEPTH))
                  + ADDR_W'(entry_index);
  assign mem_wdata = WEIGHT_BITS'(weight_value);

  pwsc_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (DEPTH)
  ) u_weights (
    .clk   (clk),
    .we    (accept && (op == OP_WRITE) && addr_ok),
    .waddr (mem_addr),
    .wdata (mem_wdata),
    .re    (accept && (op == OP_LOOKUP)),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  // Stage advances unless its result must wait for the output register
  assign s1_emit  = s1_valid && s1_last;
  assign s1_go    = s1_valid && (!s1_emit || !out_valid || m_tready);
  assign s_tready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid && (op == OP_LOOKUP);
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      s1_ok   <= addr_ok;
      s1_last <= s_tlast;
    end
  end

  // Add, saturate to the accumulator range, then clamp to the limit
  always_comb begin
    weight_ext = s1_ok ? ACC_W'($signed(mem_rdata)) : '0;
    acc_wide   = ACC_W'(running_sum) + weight_ext;
    if (acc_wide > ACC_MAX) begin
      sat_sum = SUM_W'(ACC_MAX);
    end else if (acc_wide < ACC_MIN) begin
      sat_sum = SUM_W'(ACC_MIN);
    end else begin
      sat_sum = SUM_W'(acc_wide);
    end
    lim_pos = SUM_W'(score_limit);
    lim_neg = -lim_pos;
    if (sat_sum > lim_pos) begin
      clamped = lim_pos;
    end else if (sat_sum < lim_neg) begin
      clamped = lim_neg;
    end else begin
      clamped = sat_sum;
    end
    running_sum_next = s1_last ? '0 : sat_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (s1_go) begin
      running_sum <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit) begin
      score <= SCORE_W'(clamped);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      score_limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      score_limit <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = score;

  // The sum restarts after every emitted score
  a_sum_cleared: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_last |=> running_sum == '0)
    else $error("running sum not cleared after last lookup");

  // The lookup stage holds only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |-> s1_last && out_valid && !m_tready)
    else $error("lookup stage stalled without a waiting result");

  // A held lookup keeps its flags and the weight it adds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_last) && $stable(weight_ext))
    else $error("stalled lookup lost its contents");

  // No new input while the stage is held
  a_no_accept_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |-> !s_tready)
    else $error("input accepted while lookup stage held");

endmodule
